// ===== src/locale_tag_fallback_lookup_unit_macros.svh =====
// assertion macros used by the checker of this block
`ifndef LOCALE_TAG_FALLBACK_LOOKUP_UNIT_MACROS_SVH
`define LOCALE_TAG_FALLBACK_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define LTFL_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ltfl check failed");

// next-cycle implication, masked while reset is held
`define LTFL_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ltfl check failed");

// next-cycle implication that also holds across reset
`define LTFL_CHK_NEXT_ALL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ltfl check failed");

`endif

// ===== src/ltfl_pkg.sv =====
package ltfl_pkg;

    localparam int MAX_TAG_LENGTH_DEF = 48;
    localparam int TABLE_ENTRIES_DEF  = 64;
    localparam int LEN_W              = 7;

    // command codes
    localparam logic [1:0] CMD_TBYTE = 2'd0;
    localparam logic [1:0] CMD_TLEN  = 2'd1;
    localparam logic [1:0] CMD_QCHAR = 2'd2;

    // characters
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

    typedef enum logic [1:0] {
        K_TBYTE,
        K_TLEN,
        K_QCHAR
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         entry;
        logic [5:0]         position;
        logic [7:0]         data;
        logic [LEN_W-1:0]   len;
        logic               qwrite;
        logic               last;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_queue_head;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_LEN,
        S_ISSUE,
        S_CHECK,
        S_TRIM_RD,
        S_TRIM_CHK
    } t_state;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

endpackage

// ===== src/ltfl_front.sv =====
module ltfl_front #(
    parameter int MAX_TAG_LENGTH = 48,
    parameter int TABLE_ENTRIES  = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_command,
    input  logic [5:0]             i_entry,
    input  logic [5:0]             i_position,
    input  logic [7:0]             i_char_value,
    input  logic [5:0]             i_tag_length,
    input  logic                   i_last,
    output ltfl_pkg::t_queue_head  o_head,
    input  logic                   i_pop
);
    import ltfl_pkg::*;

    t_op        w_op;
    logic       w_keep;
    logic       w_push;
    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // classify the incoming word, dropping what has no effect
    always_comb begin
        w_op.entry    = i_entry;
        w_op.position = i_position;
        w_op.data     = (i_char_value == CH_DASH) ? CH_UNDERSCORE : i_char_value;
        w_op.len      = (int'(i_tag_length) > MAX_TAG_LENGTH) ?
                        LEN_W'(MAX_TAG_LENGTH) : LEN_W'(i_tag_length);
        w_op.qwrite   = int'(i_position) < MAX_TAG_LENGTH;
        w_op.last     = i_last;
        w_op.kind     = K_QCHAR;
        w_keep        = 1'b0;
        case (i_command)
            CMD_TBYTE: begin
                w_op.kind = K_TBYTE;
                w_op.data = i_char_value;
                w_keep    = int'(i_entry) < TABLE_ENTRIES &&
                            int'(i_position) < MAX_TAG_LENGTH;
            end
            CMD_TLEN: begin
                w_op.kind = K_TLEN;
                w_keep    = int'(i_entry) < TABLE_ENTRIES;
            end
            CMD_QCHAR: begin
                w_op.kind = K_QCHAR;
                w_keep    = w_op.qwrite || i_last;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign busy   = (r_cnt == 2'd2);
    assign w_push = start && !busy && w_keep;

    // two-slot queue toward the search engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_op;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_slot[r_rp];

endmodule

// ===== src/ltfl_back.sv =====
module ltfl_back #(
    parameter int MAX_TAG_LENGTH = 48,
    parameter int TABLE_ENTRIES  = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ltfl_pkg::t_queue_head  i_head,
    output logic                   o_pop,
    input  logic                   i_cfg_valid,
    input  logic [6:0]             i_cfg_data,
    output logic                   o_result_valid,
    output logic                   o_found,
    output logic [5:0]             o_entry_index,
    output logic [5:0]             o_matched_length
);
    import ltfl_pkg::*;

    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = $clog2(MAX_TAG_LENGTH + 1);
    localparam int PW = $clog2(MAX_TAG_LENGTH);
    localparam int AW = $clog2(TABLE_ENTRIES * MAX_TAG_LENGTH);

    // storage
    logic [7:0]    r_qmem [MAX_TAG_LENGTH];
    logic [7:0]    r_tmem [TABLE_ENTRIES * MAX_TAG_LENGTH];
    logic [LW-1:0] r_lmem [TABLE_ENTRIES];
    logic [7:0]    r_qrd;
    logic [7:0]    r_trd;
    logic [LW-1:0] r_lrd;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [LW-1:0] r_qlen, n_qlen;
    logic [LW-1:0] r_len, n_len;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [EW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_base, n_base;
    logic [LW-1:0] r_tlen, n_tlen;
    logic [LW-1:0] r_n, n_n;
    logic [LW-1:0] r_i, n_i;
    logic          r_res_valid, n_res_valid;
    logic          r_found, n_found;
    logic [5:0]    r_idx, n_idx;
    logic [5:0]    r_mlen, n_mlen;

    logic          q_we, t_we, l_we;
    logic [PW-1:0] q_raddr;
    logic [AW-1:0] t_raddr;
    logic [EW-1:0] l_raddr;
    logic [CW:0]   w_mid_sum;
    logic [7:0]    w_fa, w_fb;
    logic          go_lt, go_gt, go_hit, go_miss;
    t_op           w_op;

    assign w_op      = i_head.op;
    assign w_mid_sum = ({1'b0, r_lo} + {1'b0, r_hi} - (CW + 1)'(1)) >> 1;
    assign w_fa      = fold_case(r_qrd);
    assign w_fb      = fold_case(r_trd);

    // memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[PW'(w_op.position)] <= w_op.data;
        end
        r_qrd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[AW'(w_op.entry) * AW'(MAX_TAG_LENGTH) + AW'(w_op.position)] <= w_op.data;
        end
        r_trd <= r_tmem[t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[EW'(w_op.entry)] <= LW'(w_op.len);
        end
        r_lrd <= r_lmem[l_raddr];
    end

    // entry count register, saturated to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= (int'(i_cfg_data) > TABLE_ENTRIES) ?
                       CW'(TABLE_ENTRIES) : CW'(i_cfg_data);
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qlen      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qlen      <= n_qlen;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_base  <= n_base;
        r_tlen  <= n_tlen;
        r_n     <= n_n;
        r_i     <= n_i;
        r_found <= n_found;
        r_idx   <= n_idx;
        r_mlen  <= n_mlen;
    end

    // search sequencer: binary search probes, byte compares, subtag trimming
    always_comb begin
        n_state     = r_state;
        n_qlen      = r_qlen;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_base      = r_base;
        n_tlen      = r_tlen;
        n_n         = r_n;
        n_i         = r_i;
        n_res_valid = 1'b0;
        n_found     = r_found;
        n_idx       = r_idx;
        n_mlen      = r_mlen;
        o_pop       = 1'b0;
        q_we        = 1'b0;
        t_we        = 1'b0;
        l_we        = 1'b0;
        q_raddr     = '0;
        t_raddr     = '0;
        l_raddr     = '0;
        go_lt       = 1'b0;
        go_gt       = 1'b0;
        go_hit      = 1'b0;
        go_miss     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (w_op.kind)
                        K_TBYTE: t_we = 1'b1;
                        K_TLEN:  l_we = 1'b1;
                        K_QCHAR: begin
                            q_we  = w_op.qwrite;
                            n_len = w_op.qwrite ? LW'(w_op.position) + LW'(1) : r_qlen;
                            if (w_op.qwrite) begin
                                n_qlen = LW'(w_op.position) + LW'(1);
                            end
                            if (w_op.last) begin
                                n_state = S_START;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_START: begin
                if (r_len == '0) begin
                    go_miss = 1'b1;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo >= r_hi) begin
                    n_state = S_TRIM_RD;
                end else begin
                    n_mid   = EW'(w_mid_sum);
                    n_base  = AW'(EW'(w_mid_sum)) * AW'(MAX_TAG_LENGTH);
                    l_raddr = EW'(w_mid_sum);
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_tlen  = r_lrd;
                n_n     = (r_len < r_lrd) ? r_len : r_lrd;
                n_i     = '0;
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (r_i == r_n) begin
                    if (r_len == r_tlen) begin
                        go_hit = 1'b1;
                    end else if (r_len < r_tlen) begin
                        go_lt = 1'b1;
                    end else begin
                        go_gt = 1'b1;
                    end
                end else begin
                    q_raddr = PW'(r_i);
                    t_raddr = r_base + AW'(r_i);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_fa != w_fb) begin
                    go_lt = (w_fa < w_fb);
                    go_gt = (w_fa > w_fb);
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = S_ISSUE;
                end
            end
            S_TRIM_RD: begin
                if (r_len == '0) begin
                    go_miss = 1'b1;
                end else begin
                    q_raddr = PW'(r_len - LW'(1));
                    n_state = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK: begin
                n_len   = r_len - LW'(1);
                n_state = (r_qrd == CH_UNDERSCORE) ? S_START : S_TRIM_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // probe outcome
        if (go_lt) begin
            n_hi    = CW'(r_mid);
            n_state = S_PROBE;
        end
        if (go_gt) begin
            n_lo    = CW'(r_mid) + CW'(1);
            n_state = S_PROBE;
        end
        if (go_hit || go_miss) begin
            n_res_valid = 1'b1;
            n_found     = go_hit;
            n_idx       = go_hit ? 6'(r_mid) : 6'd0;
            n_mlen      = go_hit ? 6'(r_len) : 6'd0;
            n_qlen      = '0;
            n_state     = S_IDLE;
        end
    end

    assign o_result_valid   = r_res_valid;
    assign o_found          = r_found;
    assign o_entry_index    = r_idx;
    assign o_matched_length = r_mlen;

endmodule

// ===== src/locale_tag_fallback_lookup_unit.sv =====
// channel   | handshake                  | words
// ----------+----------------------------+------------------------------------------
// command   | start in, busy out         | command, entry, position, char, length, last
// config    | i_cfg_valid, o_cfg_ready   | entry_count (7 bits)
// result    | o_result_valid strobe      | found, entry_index, matched_length
//
// table and query words are popped from the queue head while the sequencer is idle; busy
// rises only when the two-slot queue is full. a closing query word leaves the queue, then
// per fallback prefix a setup state runs, then up to floor(log2(entry_count)) + 1 probes,
// each a length read plus byte compares; a trimmed byte is read, then checked.
// reset clears the queue, the sequencer, the query length and entry_count.
// the result is shown for one cycle and cannot be held off.
module locale_tag_fallback_lookup_unit #(
    parameter int MAX_TAG_LENGTH = ltfl_pkg::MAX_TAG_LENGTH_DEF,
    parameter int TABLE_ENTRIES  = ltfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [5:0] i_entry,
    input  logic [5:0] i_position,
    input  logic [7:0] i_char_value,
    input  logic [5:0] i_tag_length,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    output logic       o_result_valid,
    output logic       o_found,
    output logic [5:0] o_entry_index,
    output logic [5:0] o_matched_length
);
    import ltfl_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;

    // front: accept and classify into the queue
    ltfl_front #(
        .MAX_TAG_LENGTH (MAX_TAG_LENGTH),
        .TABLE_ENTRIES  (TABLE_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_entry      (i_entry),
        .i_position   (i_position),
        .i_char_value (i_char_value),
        .i_tag_length (i_tag_length),
        .i_last       (i_last),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: storage and search engine
    ltfl_back #(
        .MAX_TAG_LENGTH (MAX_TAG_LENGTH),
        .TABLE_ENTRIES  (TABLE_ENTRIES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_found          (o_found),
        .o_entry_index    (o_entry_index),
        .o_matched_length (o_matched_length)
    );

endmodule

// ===== src/ltfl_checker.sv =====
`include "locale_tag_fallback_lookup_unit_macros.svh"

module ltfl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_result_valid,
    input logic       o_found,
    input logic [5:0] o_entry_index,
    input logic [5:0] o_matched_length
);

    // a miss reports zero index and zero length
    `LTFL_CHK_NOW(a_miss_zero, o_result_valid && !o_found, o_entry_index == 6'd0 && o_matched_length == 6'd0)

    // a hit always matched a non-empty prefix
    `LTFL_CHK_NOW(a_hit_len, o_result_valid && o_found, o_matched_length != 6'd0)

    // the sequencer returns to idle after each result, so strobes never touch
    `LTFL_CHK_NEXT(a_strobe_gap, o_result_valid, !o_result_valid)

    // no result right out of reset
    `LTFL_CHK_NEXT_ALL(a_reset_quiet, !i_rst_n, !o_result_valid)

endmodule

bind locale_tag_fallback_lookup_unit ltfl_checker u_ltfl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_result_valid   (o_result_valid),
    .o_found          (o_found),
    .o_entry_index    (o_entry_index),
    .o_matched_length (o_matched_length)
);

// ===== tb/locale_tag_fallback_lookup_unit_tb.sv =====
module locale_tag_fallback_lookup_unit_tb;
    import ltfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN  = 48;
    localparam int ENTRIES  = 64;
    localparam int ITEM_TARGET = 1700;
    // command code with no function in the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [5:0] entry;
        logic [5:0] pos;
        logic [7:0] ch;
        logic [5:0] tlen;
        logic       last;
    } t_word;

    typedef struct {
        logic       found;
        logic [5:0] index;
        logic [5:0] mlen;
    } t_lookup;

    typedef logic [7:0] t_tag[$];

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_command;
    logic [5:0] i_entry;
    logic [5:0] i_position;
    logic [7:0] i_char_value;
    logic [5:0] i_tag_length;
    logic       i_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;
    logic       o_result_valid;
    logic       o_found;
    logic [5:0] o_entry_index;
    logic [5:0] o_matched_length;

    locale_tag_fallback_lookup_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_entry          (i_entry),
        .i_position       (i_position),
        .i_char_value     (i_char_value),
        .i_tag_length     (i_tag_length),
        .i_last           (i_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_found          (o_found),
        .o_entry_index    (o_entry_index),
        .o_matched_length (o_matched_length)
    );

    // shadow copy of the block state
    logic [7:0] tbl_bytes [ENTRIES][MAX_LEN];
    int         tbl_len [ENTRIES];
    logic [7:0] qry_bytes [MAX_LEN];
    int         qry_len;
    int         entry_count;
    t_tag       tags [ENTRIES];

    t_lookup pending_lookups[$];
    int      mismatches;
    int      items_sent;
    bit      idle_enabled;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    // three-way compare of the query prefix with one table entry
    function automatic int compare_prefix(input int plen, input int e);
        int n;
        logic [7:0] a;
        logic [7:0] b;
        n = plen < tbl_len[e] ? plen : tbl_len[e];
        for (int i = 0; i < n; i++) begin
            a = lower_case(qry_bytes[i]);
            b = lower_case(tbl_bytes[e][i]);
            if (a != b) return a < b ? -1 : 1;
        end
        if (plen == tbl_len[e]) return 0;
        return plen < tbl_len[e] ? -1 : 1;
    endfunction

    function automatic int bisect_table(input int plen);
        int lo;
        int hi;
        int mid;
        int order;
        lo = 0;
        hi = (entry_count < ENTRIES ? entry_count : ENTRIES) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            order = compare_prefix(plen, mid);
            if (order < 0) hi = mid - 1;
            else if (order > 0) lo = mid + 1;
            else return mid;
        end
        return -1;
    endfunction

    // update shadow state for one accepted word, queue the lookup it yields
    task automatic predict_word(input t_word w);
        int l;
        int hit;
        t_lookup r;
        case (w.cmd)
            CMD_TBYTE: if (w.pos < MAX_LEN) tbl_bytes[w.entry][w.pos] = w.ch;
            CMD_TLEN:  tbl_len[w.entry] = w.tlen > MAX_LEN ? MAX_LEN : w.tlen;
            CMD_QCHAR: begin
                if (w.pos < MAX_LEN) begin
                    qry_bytes[w.pos] = (w.ch == CH_DASH) ? CH_UNDERSCORE : w.ch;
                    qry_len = w.pos + 1;
                end
                if (w.last) begin
                    l = qry_len;
                    hit = -1;
                    while (l > 0) begin
                        hit = bisect_table(l);
                        if (hit >= 0) break;
                        while (l > 0 && qry_bytes[l-1] != CH_UNDERSCORE) l--;
                        if (l > 0) l--;
                    end
                    qry_len = 0;
                    r.found = hit >= 0;
                    r.index = hit >= 0 ? hit[5:0] : 6'd0;
                    r.mlen  = hit >= 0 ? l[5:0] : 6'd0;
                    pending_lookups.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // send one word over the start/busy handshake
    task automatic send_word(input t_word w);
        if (idle_enabled && $urandom_range(0, 99) < 6) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_command    = w.cmd;
        i_entry      = w.entry;
        i_position   = w.pos;
        i_char_value = w.ch;
        i_tag_length = w.tlen;
        i_last       = w.last;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_word(w);
        items_sent++;
    endtask

    task automatic send_fields(input logic [1:0] cmd, input int e, input int p,
                               input logic [7:0] ch, input int tl, input logic lst);
        t_word w;
        w.cmd = cmd; w.entry = 6'(e); w.pos = 6'(p); w.ch = ch; w.tlen = 6'(tl);
        w.last = lst;
        send_word(w);
    endtask

    // write one table entry, bytes and length
    task automatic load_entry(input int e, input t_tag t, input int tl);
        for (int i = 0; i < t.size(); i++)
            send_fields(CMD_TBYTE, e, i, t[i], $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
        send_fields(CMD_TLEN, e, $urandom_range(0, 63), 8'($urandom), tl,
                    1'($urandom_range(0, 1)));
        tags[e] = t;
    endtask

    // send a query one character per word; optionally close it with a dropped char
    task automatic send_query(input t_tag q, input bit overlong_close);
        for (int i = 0; i < q.size(); i++)
            send_fields(CMD_QCHAR, $urandom, i, q[i], $urandom_range(0, 63),
                        !overlong_close && i == q.size() - 1);
        if (overlong_close || q.size() == 0)
            send_fields(CMD_QCHAR, $urandom, $urandom_range(MAX_LEN, 63), 8'($urandom),
                        $urandom_range(0, 63), 1'b1);
    endtask

    // write entry_count once the block has gone quiet
    task automatic write_entry_count(input int value);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = 7'(value);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        entry_count = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_tag str_tag(input string s);
        t_tag t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic int tag_order(input t_tag a, input t_tag b);
        int n;
        n = a.size() < b.size() ? a.size() : b.size();
        for (int i = 0; i < n; i++)
            if (lower_case(a[i]) != lower_case(b[i]))
                return lower_case(a[i]) < lower_case(b[i]) ? -1 : 1;
        return a.size() == b.size() ? 0 : (a.size() < b.size() ? -1 : 1);
    endfunction

    function automatic logic [7:0] random_tag_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8'($urandom);
        if (r < 25) return CH_UNDERSCORE;
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "A";
            default: return "B";
        endcase
    endfunction

    function automatic t_tag random_tag();
        t_tag t;
        int n;
        int r;
        r = $urandom_range(0, 99);
        n = r < 3 ? MAX_LEN : (r < 6 ? 0 : $urandom_range(1, 7));
        repeat (n) t.push_back(random_tag_char());
        return t;
    endfunction

    // derive a query from a stored tag: case flips, dashes, extra subtags
    function automatic t_tag query_from_tag(input t_tag src);
        t_tag q;
        foreach (src[i]) begin
            if (src[i] == CH_UNDERSCORE && $urandom_range(0, 1)) q.push_back(CH_DASH);
            else if (lower_case(src[i]) != src[i] && $urandom_range(0, 1))
                q.push_back(lower_case(src[i]));
            else if (src[i] >= "a" && src[i] <= "z" && $urandom_range(0, 1))
                q.push_back(src[i] - CASE_OFFSET);
            else q.push_back(src[i]);
        end
        if ($urandom_range(0, 1)) begin
            q.push_back($urandom_range(0, 1) ? CH_DASH : CH_UNDERSCORE);
            repeat ($urandom_range(1, 4)) q.push_back(random_tag_char());
        end
        while (q.size() > MAX_LEN) void'(q.pop_back());
        return q;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (i_rst_n && o_result_valid) begin
            if (pending_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: found=%0b index=%0d len=%0d",
                             o_found, o_entry_index, o_matched_length);
            end else begin
                exp_r = pending_lookups.pop_front();
                if (o_found !== exp_r.found || o_entry_index !== exp_r.index ||
                    o_matched_length !== exp_r.mlen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("lookup mismatch: exp %0b/%0d/%0d got %0b/%0d/%0d",
                                 exp_r.found, exp_r.index, exp_r.mlen,
                                 o_found, o_entry_index, o_matched_length);
                end
            end
        end
    end

    // empty table and empty query
    task automatic test_empty_table();
        write_entry_count(0);
        send_query(str_tag("ab"), 1'b0);
        send_query(str_tag(""), 1'b1);
    endtask

    // small sorted table with exact, fallback, case and length corner queries
    task automatic test_directed_lookups();
        string names[8] = '{"de", "de_AT", "en", "en_GB", "en_US", "fr", "zh", "zh_Hant"};
        t_tag zz;
        foreach (names[i]) load_entry(i, str_tag(names[i]), names[i].len());
        repeat (MAX_LEN) zz.push_back("z");
        load_entry(8, zz, 63);
        // byte past the tag limit is ignored
        send_fields(CMD_TBYTE, 2, 50, "q", 0, 1'b0);
        send_fields(CMD_UNUSED, 63, 63, 8'hFF, 63, 1'b1);
        write_entry_count(9);
        send_query(str_tag("EN-us"), 1'b0);
        send_query(str_tag("en_US_basic"), 1'b0);
        send_query(str_tag("de-CH"), 1'b0);
        send_query(str_tag("zh-Hant-HK"), 1'b0);
        send_query(str_tag("xx"), 1'b0);
        send_query(str_tag("_"), 1'b0);
        for (int i = 0; i < MAX_LEN; i++) zz[i] = "Z";
        send_query(zz, 1'b0);
        send_query(zz, 1'b1);
    endtask

    // random tables and queries across entry_count settings
    task automatic test_random_lookups();
        t_tag t;
        t_tag fresh[$];
        t_tag tmp;
        int n;
        int r;
        int cnt;
        // define every entry once so any count stays within written storage
        for (int e = 0; e < ENTRIES; e++) begin
            t = random_tag();
            load_entry(e, t, t.size() == MAX_LEN ? $urandom_range(MAX_LEN, 63) : t.size());
        end
        write_entry_count(127);
        while (items_sent < ITEM_TARGET) begin
            idle_enabled = !(items_sent > 900 && items_sent < 1200);
            n = $urandom_range(1, 12);
            fresh.delete();
            repeat (n) fresh.push_back(random_tag());
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n - 1 - i; j++)
                    if (tag_order(fresh[j], fresh[j+1]) > 0) begin
                        tmp = fresh[j]; fresh[j] = fresh[j+1]; fresh[j+1] = tmp;
                    end
            for (int i = 0; i < n; i++)
                load_entry(i, fresh[i],
                           fresh[i].size() == MAX_LEN ? $urandom_range(MAX_LEN, 63)
                                                      : fresh[i].size());
            r = $urandom_range(0, 99);
            cnt = r < 55 ? n : r < 70 ? ENTRIES : r < 80 ? 127 : r < 88 ? 0
                : $urandom_range(0, 127);
            write_entry_count(cnt);
            repeat ($urandom_range(4, 10)) begin
                if ($urandom_range(0, 99) < 5)
                    send_fields(CMD_UNUSED, $urandom, $urandom, 8'($urandom), $urandom,
                                1'($urandom));
                if ($urandom_range(0, 99) < 80)
                    t = query_from_tag(tags[$urandom_range(0, n - 1)]);
                else
                    t = random_tag();
                send_query(t, $urandom_range(0, 99) < 10);
            end
        end
    endtask

    initial begin
        start        = 1'b0;
        i_command    = CMD_TBYTE;
        i_entry      = '0;
        i_position   = '0;
        i_char_value = '0;
        i_tag_length = '0;
        i_last       = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        qry_len      = 0;
        entry_count  = 0;
        mismatches   = 0;
        items_sent   = 0;
        idle_enabled = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed_lookups();
        test_random_lookups();

        @(negedge i_clk);
        start = 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #400_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== locale_tag_fallback_lookup_unit.f =====
+incdir+src
src/ltfl_pkg.sv
src/ltfl_front.sv
src/ltfl_back.sv
src/locale_tag_fallback_lookup_unit.sv
src/ltfl_checker.sv
tb/locale_tag_fallback_lookup_unit_tb.sv
